### sv/tli_pkg.sv
package tli_pkg;

  // default field widths
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_V0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V2Y = 3'd5;

  // result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  // flags that travel with a word through the divider chain
  typedef struct packed {
    logic ovf;   // quotient grew beyond the result width
    logic rneg;  // result is negative
    logic deg;   // zero-area triangle
  } div_flags_t;

endpackage

### sv/tli_div_cell.sv
module tli_div_cell #(
  parameter int unsigned NB = 55,
  parameter int unsigned EW = 36,
  parameter int unsigned QW = 16,
  parameter int unsigned K  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  output logic                en_o,
  input  logic                valid_i,
  input  logic [NB-1:0]       n_i,
  input  logic [EW-1:0]       e_i,
  input  logic [EW-1:0]       rem_i,
  input  logic [QW-1:0]       q_i,
  input  tli_pkg::div_flags_t flags_i,
  output logic                valid_o,
  output logic [NB-1:0]       n_o,
  output logic [EW-1:0]       e_o,
  output logic [EW-1:0]       rem_o,
  output logic [QW-1:0]       q_o,
  output tli_pkg::div_flags_t flags_o
);

  logic                valid_q;
  logic [NB-1:0]       n_q;
  logic [EW-1:0]       e_q;
  logic [EW-1:0]       rem_q, rem_d;
  logic [QW-1:0]       q_q, q_d;
  tli_pkg::div_flags_t flags_q, flags_d;
  logic [EW:0]         rem_s;
  logic                ge;

  // one restoring step: bring down numerator bit K
  always_comb begin
    rem_s = {rem_i, n_i[K]};
    ge    = rem_s >= {1'b0, e_i};
    rem_d = ge ? EW'(rem_s - {1'b0, e_i}) : rem_s[EW-1:0];
    q_d   = {q_i[QW-2:0], ge};
    flags_d     = flags_i;
    flags_d.ovf = flags_i.ovf | q_i[QW-1];
  end

  assign en_o = !valid_q || en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      n_q     <= n_i;
      e_q     <= e_i;
      rem_q   <= rem_d;
      q_q     <= q_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign e_o     = e_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign flags_o = flags_q;

endmodule

### sv/triangle_linear_interpolator.sv
// Linear interpolation over one triangle whose vertices sit in six config
// registers. Each input word carries a query point and the three vertex
// values; each output word carries the interpolated value, rounded to
// nearest (half away from zero) and saturated, with a status in tuser
// (ok, zero-area triangle, saturated). One word is accepted per clock unless
// output back-pressure fills the pipeline: five arithmetic stages, a chain
// of restoring divider cells with one cell per numerator bit, and the output
// register. Bubbles are squeezed out when the output is stalled. The user
// must write config only while the block is idle; it is not enforced.
module triangle_linear_interpolator #(
  parameter int unsigned COORD_BITS = tli_pkg::COORD_BITS_DEF,
  parameter int unsigned VALUE_BITS = tli_pkg::VALUE_BITS_DEF,
  localparam int unsigned IN_W = ((2*COORD_BITS + 3*VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // point_x, point_y, value_at_v0, value_at_v1, value_at_v2, zero fill
  input  logic [IN_W-1:0]                s_axis_tdata,
  // output words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // interpolated, zero fill
  output logic [OUT_W-1:0]               m_axis_tdata,
  // status
  output logic [tli_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned V   = VALUE_BITS;
  localparam int unsigned GW  = 2*C + 3;        // g_i and f
  localparam int unsigned H   = GW / 2;         // low split of g
  localparam int unsigned PLW = V + H + 1;
  localparam int unsigned PHW = V + GW - H;
  localparam int unsigned PW  = V + GW + 2;     // accumulated sum
  localparam int unsigned NB  = PW + 2;         // 2N + D
  localparam int unsigned EW  = GW + 1;         // 2D

  // configuration registers
  logic signed [C-1:0] vx_q [3];
  logic signed [C-1:0] vy_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tli_pkg::CFG_V0X: vx_q[0] <= cfg_data_i;
        tli_pkg::CFG_V0Y: vy_q[0] <= cfg_data_i;
        tli_pkg::CFG_V1X: vx_q[1] <= cfg_data_i;
        tli_pkg::CFG_V1Y: vy_q[1] <= cfg_data_i;
        tli_pkg::CFG_V2X: vx_q[2] <= cfg_data_i;
        tli_pkg::CFG_V2Y: vy_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input unpacking
  logic signed [C-1:0] px, py;
  logic signed [V-1:0] vin [3];
  assign px = s_axis_tdata[C-1:0];
  assign py = s_axis_tdata[2*C-1:C];
  assign vin[0] = s_axis_tdata[2*C+V-1:2*C];
  assign vin[1] = s_axis_tdata[2*C+2*V-1:2*C+V];
  assign vin[2] = s_axis_tdata[2*C+3*V-1:2*C+2*V];

  // stage valids and enables, squeezing bubbles
  logic [4:0] v_q;
  logic [4:0] en;
  logic       cell_en0;
  logic       out_en;

  assign en[4] = !v_q[4] || cell_en0;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: coefficient products and point products
  logic signed [2*C-1:0] a1_q [3];
  logic signed [2*C-1:0] a2_q [3];
  logic signed [2*C:0]   xb_q [3];
  logic signed [2*C:0]   yc_q [3];
  logic signed [V-1:0]   val1_q [3];
  logic signed [C:0]     cb [3];
  logic signed [C:0]     cc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cb[i] = (C+1)'(vy_q[(i+1)%3]) - (C+1)'(vy_q[(i+2)%3]);
      cc[i] = (C+1)'(vx_q[(i+2)%3]) - (C+1)'(vx_q[(i+1)%3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i]   <= vx_q[(i+1)%3] * vy_q[(i+2)%3];
        a2_q[i]   <= vx_q[(i+2)%3] * vy_q[(i+1)%3];
        xb_q[i]   <= px * cb[i];
        yc_q[i]   <= py * cc[i];
        val1_q[i] <= vin[i];
      end
    end
  end

  // stage 2: weights g_i and twice the area f
  logic signed [GW-1:0] g_q [3];
  logic signed [GW-1:0] f2_q;
  logic signed [V-1:0]  val2_q [3];
  logic signed [GW-1:0] ai [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ai[i] = GW'(a1_q[i]) - GW'(a2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        g_q[i]    <= ai[i] + GW'(xb_q[i]) + GW'(yc_q[i]);
        val2_q[i] <= val1_q[i];
      end
      f2_q <= ai[0] + ai[1] + ai[2];
    end
  end

  // stage 3: value times weight, split in two partial products
  logic signed [PLW-1:0] pl_q [3];
  logic signed [PHW-1:0] ph_q [3];
  logic signed [GW-1:0]  f3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= val2_q[i] * signed'({1'b0, g_q[i][H-1:0]});
        ph_q[i] <= val2_q[i] * signed'(g_q[i][GW-1:H]);
      end
      f3_q <= f2_q;
    end
  end

  // stage 4: combine partial products and accumulate
  logic signed [PW-1:0] acc_q;
  logic signed [GW-1:0] f4_q;
  logic signed [PW-1:0] prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (PW'(ph_q[i]) <<< H) + PW'(pl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      acc_q <= prod[0] + prod[1] + prod[2];
      f4_q  <= f3_q;
    end
  end

  // stage 5: magnitudes, rounding offset and signs
  logic [NB-1:0]       n5_q;
  logic [EW-1:0]       e5_q;
  tli_pkg::div_flags_t fl5_q;
  logic                acc_neg;
  logic [PW-1:0]       acc_mag;
  logic [GW-1:0]       f_mag;

  always_comb begin
    acc_neg = acc_q[PW-1];
    acc_mag = acc_neg ? PW'(-acc_q) : acc_q;
    f_mag   = f4_q[GW-1] ? GW'(-f4_q) : f4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      n5_q       <= {1'b0, acc_mag, 1'b0} + NB'(f_mag);
      e5_q       <= {f_mag, 1'b0};
      fl5_q.ovf  <= 1'b0;
      fl5_q.rneg <= acc_neg ^ f4_q[GW-1];
      fl5_q.deg  <= (f4_q == '0);
    end
  end

  // divider chain, one cell per numerator bit, most significant first
  logic                cv   [NB+1];
  logic                cen  [NB+1];
  logic [NB-1:0]       cn   [NB+1];
  logic [EW-1:0]       ce   [NB+1];
  logic [EW-1:0]       crem [NB+1];
  logic [V-1:0]        cq   [NB+1];
  tli_pkg::div_flags_t cfl  [NB+1];

  assign cv[0]   = v_q[4];
  assign cn[0]   = n5_q;
  assign ce[0]   = e5_q;
  assign crem[0] = '0;
  assign cq[0]   = '0;
  assign cfl[0]  = fl5_q;
  assign cell_en0 = cen[0];
  assign cen[NB]  = out_en;

  for (genvar j = 0; j < NB; j++) begin : g_cell
    tli_div_cell #(
      .NB (NB),
      .EW (EW),
      .QW (V),
      .K  (NB-1-j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (cen[j+1]),
      .en_o    (cen[j]),
      .valid_i (cv[j]),
      .n_i     (cn[j]),
      .e_i     (ce[j]),
      .rem_i   (crem[j]),
      .q_i     (cq[j]),
      .flags_i (cfl[j]),
      .valid_o (cv[j+1]),
      .n_o     (cn[j+1]),
      .e_o     (ce[j+1]),
      .rem_o   (crem[j+1]),
      .q_o     (cq[j+1]),
      .flags_o (cfl[j+1])
    );
  end

  // sign, saturation and output register
  logic                         out_v_q;
  logic signed [V-1:0]          res_q, res_d;
  logic [tli_pkg::STATUS_W-1:0] st_q, st_d;
  logic [V-1:0]                 qf;
  tli_pkg::div_flags_t          ff;

  assign out_en = !out_v_q || m_axis_tready;

  always_comb begin
    qf = cq[NB];
    ff = cfl[NB];
    if (ff.deg) begin
      res_d = '0;
      st_d  = tli_pkg::ST_DEGEN;
    end else if (ff.rneg) begin
      if (ff.ovf || (qf[V-1] && (qf[V-2:0] != '0))) begin
        res_d = {1'b1, {(V-1){1'b0}}};
        st_d  = tli_pkg::ST_SAT;
      end else begin
        res_d = -signed'(qf);
        st_d  = tli_pkg::ST_OK;
      end
    end else begin
      if (ff.ovf || qf[V-1]) begin
        res_d = {1'b0, {(V-1){1'b1}}};
        st_d  = tli_pkg::ST_SAT;
      end else begin
        res_d = signed'(qf);
        st_d  = tli_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= cv[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'(unsigned'(res_q));
  assign m_axis_tuser  = st_q;

endmodule
